>>> src/bcs_pkg.sv
// Package for the bracket completion stack: item types, request codes,
// controller states and the opener/closer decode functions.
// No dependencies.
package bcs_pkg;

  // Widths fixed by the item fields
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned PEND_W    = 6;
  localparam int unsigned CODE_W    = 2;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_TEXT     = 2'd0;
  localparam logic [REQ_W-1:0] REQ_COMPLETE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;

  // Bracket characters
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;  // {
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;  // }
  localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;  // [
  localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;  // ]
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;  // (
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;  // )
  localparam logic [CHAR_W-1:0] CH_LANGLE = 8'h3C;  // <
  localparam logic [CHAR_W-1:0] CH_RANGLE = 8'h3E;  // >

  // Closer codes as stored on the stack
  localparam logic [CODE_W-1:0] CODE_BRACE = 2'd0;
  localparam logic [CODE_W-1:0] CODE_BRACK = 2'd1;
  localparam logic [CODE_W-1:0] CODE_PAREN = 2'd2;
  localparam logic [CODE_W-1:0] CODE_ANGLE = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]  req_type;
    logic [CHAR_W-1:0] text_byte;
  } bcs_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] closer_char;
    logic              has_char;
    logic              last;
    logic              error_seen;
    logic              overflow_seen;
    logic [PEND_W-1:0] pending_count;
  } bcs_rsp_t;

  typedef struct packed {
    logic              hit;
    logic [CODE_W-1:0] code;
  } bcs_decode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } bcs_state_t;

  // Map an opener byte to the code of its closer
  function automatic bcs_decode_t opener_decode(input logic [CHAR_W-1:0] b);
    bcs_decode_t d;
    d.hit  = 1'b1;
    d.code = CODE_BRACE;
    unique case (b)
      CH_LBRACE: d.code = CODE_BRACE;
      CH_LBRACK: d.code = CODE_BRACK;
      CH_LPAREN: d.code = CODE_PAREN;
      CH_LANGLE: d.code = CODE_ANGLE;
      default:   d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  // Map a closer byte to its code
  function automatic bcs_decode_t closer_decode(input logic [CHAR_W-1:0] b);
    bcs_decode_t d;
    d.hit  = 1'b1;
    d.code = CODE_BRACE;
    unique case (b)
      CH_RBRACE: d.code = CODE_BRACE;
      CH_RBRACK: d.code = CODE_BRACK;
      CH_RPAREN: d.code = CODE_PAREN;
      CH_RANGLE: d.code = CODE_ANGLE;
      default:   d.hit  = 1'b0;
    endcase
    return d;
  endfunction

  // Closer character for a stored code
  function automatic logic [CHAR_W-1:0] closer_char_of(input logic [CODE_W-1:0] c);
    logic [CHAR_W-1:0] ch;
    unique case (c)
      CODE_BRACE: ch = CH_RBRACE;
      CODE_BRACK: ch = CH_RBRACK;
      CODE_PAREN: ch = CH_RPAREN;
      CODE_ANGLE: ch = CH_RANGLE;
      default:    ch = CH_RBRACE;
    endcase
    return ch;
  endfunction

endpackage

>>> src/bcs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Read data holds while the read enable is low. No dependencies.
module bcs_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/bracket_completion_stack_core.sv
// Top level of the bracket completion stack: controller, read pipeline and
// result register around one closer-stack RAM.
// Depends on bcs_pkg and bcs_ram.
//
//   channel | signals                    | direction | carries
//   --------+----------------------------+-----------+-------------------------
//   request | req_valid, req_ready, req  | in        | bcs_req_t text/cmd item
//   result  | rsp_valid, rsp_ready, rsp  | out       | bcs_rsp_t closer item
//
// Text bytes and clear requests produce no result.
// A complete request with n closers pending walks the RAM read port one
// entry per cycle while the result side does not stall, and gives max(n, 1)
// results; requests wait until the walk and its drain state have ended.
// Result stalls stretch the walk; a text item is still taken while the last
// result waits. Reset clears count, flags and control, never the stack RAM.
module bracket_completion_stack_core #(
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  bcs_pkg::bcs_req_t req,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output bcs_pkg::bcs_rsp_t rsp
);

  import bcs_pkg::*;

  localparam int unsigned ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  // Control state
  bcs_state_t        state;
  bcs_state_t        state_next;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              error_flag;
  logic              overflow_flag;
  logic              fwd_valid;
  logic [CODE_W-1:0] fwd_code;
  logic [ADDR_W-1:0] walk_idx;

  // Read stage: rd_data carries the closer of the staged result
  logic              st_valid;
  logic              st_has;
  logic              st_last;

  // RAM port signals
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [CODE_W-1:0] rd_data;

  // Decode and control
  logic              accept;
  logic              move;
  logic              can_issue;
  logic              issue;
  logic              issue_has;
  logic              issue_last;
  logic              push;
  logic              pop;
  logic              set_err;
  logic              set_ovf;
  logic              do_clear;
  logic              walk_load;
  logic              walk_dec;
  logic [CODE_W-1:0] top_code;
  logic [CNT_W-1:0]  cnt_dec;
  logic [CNT_W-1:0]  cur_dec;
  bcs_decode_t       op_dec;
  bcs_decode_t       cl_dec;

  bcs_ram #(
    .WIDTH (CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (op_dec.code),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign move      = st_valid && (!rsp_valid || rsp_ready);
  assign can_issue = !st_valid || move;
  assign op_dec    = opener_decode(req.text_byte);
  assign cl_dec    = closer_decode(req.text_byte);
  // Forward a push that collided with the top-of-stack read
  assign top_code  = fwd_valid ? fwd_code : rd_data;
  assign cur_dec   = count - CNT_ONE;
  assign cnt_dec   = count_next - CNT_ONE;
  assign wr_en     = push;
  assign wr_addr   = count[ADDR_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (req.req_type == REQ_COMPLETE)) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (can_issue && ((count == '0) || (walk_idx == '0))) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (can_issue) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Stack update, RAM reads and walk control
  always_comb begin
    push       = 1'b0;
    pop        = 1'b0;
    set_err    = 1'b0;
    set_ovf    = 1'b0;
    do_clear   = 1'b0;
    walk_load  = 1'b0;
    walk_dec   = 1'b0;
    issue      = 1'b0;
    issue_has  = 1'b0;
    issue_last = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = walk_idx;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            REQ_TEXT: begin
              if (!error_flag) begin
                if (op_dec.hit) begin
                  if (count == CNT_FULL) begin
                    set_err = 1'b1;
                    set_ovf = 1'b1;
                  end else begin
                    push = 1'b1;
                  end
                end else if (cl_dec.hit) begin
                  if ((count != '0) && (top_code == cl_dec.code)) begin
                    pop = 1'b1;
                  end else begin
                    set_err = 1'b1;
                  end
                end
              end
            end
            REQ_COMPLETE: walk_load = 1'b1;
            REQ_CLEAR:    do_clear  = 1'b1;
            default: ;
          endcase
        end
        // Keep the top entry in the read register
        rd_en   = 1'b1;
        rd_addr = cnt_dec[ADDR_W-1:0];
      end
      ST_WALK: begin
        if (can_issue) begin
          issue = 1'b1;
          if (count == '0) begin
            issue_last = 1'b1;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = walk_idx;
            issue_has  = 1'b1;
            issue_last = (walk_idx == '0);
            walk_dec   = (walk_idx != '0);
          end
        end
      end
      ST_DRAIN: begin
        // Restore the top-of-stack read once the stage empties
        if (can_issue) begin
          rd_en   = 1'b1;
          rd_addr = cur_dec[ADDR_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_next = count;
    if (do_clear) begin
      count_next = '0;
    end else if (push) begin
      count_next = count + CNT_ONE;
    end else if (pop) begin
      count_next = count - CNT_ONE;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      error_flag    <= 1'b0;
      overflow_flag <= 1'b0;
      fwd_valid     <= 1'b0;
      st_valid      <= 1'b0;
      rsp_valid     <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      fwd_valid <= push;
      if (do_clear) begin
        error_flag    <= 1'b0;
        overflow_flag <= 1'b0;
      end else begin
        if (set_err) error_flag    <= 1'b1;
        if (set_ovf) overflow_flag <= 1'b1;
      end
      // Advance the read stage
      if (issue) begin
        st_valid <= 1'b1;
      end else if (move) begin
        st_valid <= 1'b0;
      end
      // Hold the result until taken
      if (move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (push) begin
      fwd_code <= op_dec.code;
    end
    if (walk_load) begin
      walk_idx <= cur_dec[ADDR_W-1:0];
    end else if (walk_dec) begin
      walk_idx <= walk_idx - ADDR_W'(1);
    end
    if (issue) begin
      st_has  <= issue_has;
      st_last <= issue_last;
    end
    if (move) begin
      rsp.closer_char   <= st_has ? closer_char_of(rd_data) : '0;
      rsp.has_char      <= st_has;
      rsp.last          <= st_last;
      rsp.error_seen    <= error_flag;
      rsp.overflow_seen <= overflow_flag;
      rsp.pending_count <= PEND_W'(count);
    end
  end

endmodule

>>> test/bracket_completion_stack_core_tb.sv
// Testbench for bracket_completion_stack_core: drives text, complete and clear items,
// predicts the pending closers with its own stack mirror and checks every result item.
// Depends on bcs_pkg and the bracket_completion_stack_core RTL.
`timescale 1ns / 1ps

module bracket_completion_stack_core_tb;
  import bcs_pkg::*;

  localparam int unsigned STACK_DEPTH = 32;
  localparam int unsigned IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 1000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int RANDOM_ITEMS = 320;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_ready;
  bcs_req_t req_item;
  logic rsp_valid;
  logic rsp_ready;
  bcs_rsp_t rsp_item;

  // Mirror of the block state
  logic [CODE_W-1:0] mirror_stack [STACK_DEPTH];
  int unsigned mirror_depth;
  logic mirror_error;
  logic mirror_overflow;

  // Closer items still owed by the block, oldest first
  bcs_rsp_t owed_closers [$];

  int mismatches = 0;
  int idle_cycles = 0;
  int hold_req = 0;
  bit steady_flow;

  bracket_completion_stack_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req_item),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp_item)
  );

  always #2 clk = ~clk;

  // Bracket tables of the mirror
  function automatic bit opener_code(input logic [CHAR_W-1:0] b, output logic [CODE_W-1:0] c);
    c = CODE_BRACE;
    case (b)
      CH_LBRACE: c = CODE_BRACE;
      CH_LBRACK: c = CODE_BRACK;
      CH_LPAREN: c = CODE_PAREN;
      CH_LANGLE: c = CODE_ANGLE;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic bit closer_code(input logic [CHAR_W-1:0] b, output logic [CODE_W-1:0] c);
    c = CODE_BRACE;
    case (b)
      CH_RBRACE: c = CODE_BRACE;
      CH_RBRACK: c = CODE_BRACK;
      CH_RPAREN: c = CODE_PAREN;
      CH_RANGLE: c = CODE_ANGLE;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic logic [CHAR_W-1:0] closer_for(input logic [CODE_W-1:0] c);
    case (c)
      CODE_BRACE: return CH_RBRACE;
      CODE_BRACK: return CH_RBRACK;
      CODE_PAREN: return CH_RPAREN;
      default:    return CH_RANGLE;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] opener_for(input logic [CODE_W-1:0] c);
    case (c)
      CODE_BRACE: return CH_LBRACE;
      CODE_BRACK: return CH_LBRACK;
      CODE_PAREN: return CH_LPAREN;
      default:    return CH_LANGLE;
    endcase
  endfunction

  // Push, pop or flag a text byte; ignore everything once in error
  function automatic void take_text(input logic [CHAR_W-1:0] b);
    logic [CODE_W-1:0] c;
    if (mirror_error) return;
    if (opener_code(b, c)) begin
      if (mirror_depth >= STACK_DEPTH) begin
        mirror_overflow = 1'b1;
        mirror_error = 1'b1;
      end else begin
        mirror_stack[IDX_W'(mirror_depth)] = c;
        mirror_depth++;
      end
    end else if (closer_code(b, c)) begin
      if (mirror_depth > 0 && mirror_stack[IDX_W'(mirror_depth - 1)] == c) begin
        mirror_depth--;
      end else begin
        mirror_error = 1'b1;
      end
    end
  endfunction

  // Advance the mirror by one accepted item and queue the closers it owes
  function automatic void apply_request(input bcs_req_t item);
    bcs_rsp_t r;
    int unsigned n;
    n = mirror_depth;
    r = '0;
    r.error_seen = mirror_error;
    r.overflow_seen = mirror_overflow;
    case (item.req_type)
      REQ_TEXT: take_text(item.text_byte);
      REQ_CLEAR: begin
        mirror_depth = 0;
        mirror_error = 1'b0;
        mirror_overflow = 1'b0;
      end
      REQ_COMPLETE: begin
        if (n == 0) begin
          r.last = 1'b1;
          owed_closers = {owed_closers, r};
        end else begin
          for (int unsigned k = 0; k < n; k++) begin
            r.closer_char = closer_for(mirror_stack[IDX_W'(n - 1 - k)]);
            r.has_char = 1'b1;
            r.last = (k + 1 == n);
            r.pending_count = n[PEND_W-1:0];
            owed_closers = {owed_closers, r};
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 12);
  endfunction

  // Offer one item after a random gap, hold it until accepted, then predict
  task automatic send_item(input logic [REQ_W-1:0] kind, input logic [CHAR_W-1:0] b);
    bcs_req_t item;
    int gap;
    item.req_type = kind;
    item.text_byte = b;
    gap = draw_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_item <= item;
    do @(posedge clk); while (!req_ready);
    apply_request(item);
  endtask

  task automatic send_text(input logic [CHAR_W-1:0] b);
    send_item(REQ_TEXT, b);
  endtask

  task automatic report_mismatch(input string what, input bcs_rsp_t want, input bcs_rsp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected char=%h has=%b last=%b err=%b ovf=%b pend=%0d",
               $realtime, what, want.closer_char, want.has_char, want.last,
               want.error_seen, want.overflow_seen, want.pending_count);
      $display("%0t: %s: actual   char=%h has=%b last=%b err=%b ovf=%b pend=%0d",
               $realtime, what, got.closer_char, got.has_char, got.last,
               got.error_seen, got.overflow_seen, got.pending_count);
    end
  endtask

  // Compare one accepted result with the oldest owed closer
  task automatic check_closer(input bcs_rsp_t got);
    bcs_rsp_t want;
    if (owed_closers.size() == 0) begin
      report_mismatch("unexpected result", '0, got);
    end else begin
      want = owed_closers.pop_front();
      if (got.closer_char !== want.closer_char || got.has_char !== want.has_char ||
          got.last !== want.last || got.error_seen !== want.error_seen ||
          got.overflow_seen !== want.overflow_seen || got.pending_count !== want.pending_count)
        report_mismatch("result mismatch", want, got);
    end
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin : result_sink
    int gap;
    int hold_seen;
    hold_seen = 0;
    rsp_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap();
      if (hold_req != hold_seen) begin
        gap = HOLD_OFF_CYCLES;
        hold_seen = hold_req;
      end
      if (gap > 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      check_closer(rsp_item);
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Extremes, every request kind and each special case
  task automatic test_directed();
    send_item(REQ_COMPLETE, 8'h00);
    send_text(CH_LBRACE);
    send_text(CH_LBRACK);
    send_text(CH_LPAREN);
    send_text(CH_LANGLE);
    send_item(REQ_COMPLETE, 8'hFF);
    send_text(CH_RANGLE);
    send_text(CH_RPAREN);
    send_text(CH_RBRACK);
    send_text(8'h00);
    send_text(8'hFF);
    send_item(REQ_COMPLETE, 8'h5A);
    send_text(CH_RBRACE);
    send_item(REQ_COMPLETE, 8'hA5);
    send_text(CH_LPAREN);
    send_text(CH_RBRACK);
    send_text(CH_LBRACE);
    send_item(REQ_COMPLETE, 8'h00);
    send_item(REQ_CLEAR, 8'hFF);
    send_item(REQ_UNUSED, 8'h00);
    send_item(REQ_UNUSED, 8'hFF);
    send_text(CH_RPAREN);
    send_item(REQ_COMPLETE, 8'h00);
    send_item(REQ_CLEAR, 8'h00);
  endtask

  // Fill the stack, list all closers, then push once more to overflow
  task automatic test_full_stack();
    repeat (STACK_DEPTH) send_text(opener_for(CODE_W'($urandom_range(0, 3))));
    send_item(REQ_COMPLETE, CHAR_W'($urandom_range(0, 255)));
    send_text(opener_for(CODE_W'($urandom_range(0, 3))));
    send_text(closer_for(mirror_stack[IDX_W'(STACK_DEPTH - 1)]));
    send_item(REQ_COMPLETE, CHAR_W'($urandom_range(0, 255)));
    send_item(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)));
    send_item(REQ_COMPLETE, CHAR_W'($urandom_range(0, 255)));
  endtask

  // Stall the result side while requests keep coming, so the input backs up
  task automatic test_result_stall();
    repeat (12) send_text(opener_for(CODE_W'($urandom_range(0, 3))));
    hold_req++;
    send_item(REQ_COMPLETE, 8'h00);
    send_text(CH_LPAREN);
    send_item(REQ_COMPLETE, 8'h00);
    send_item(REQ_COMPLETE, 8'h00);
    send_item(REQ_CLEAR, 8'h00);
  endtask

  // Mostly well-formed bracket text with random content, plus noise and errors
  task automatic test_random();
    int counted;
    int pick;
    logic [REQ_W-1:0] kind;
    logic [CHAR_W-1:0] b;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 64 == 0) steady_flow = ($urandom_range(0, 2) == 0);
      pick = $urandom_range(0, 99);
      b = CHAR_W'($urandom_range(0, 255));
      kind = REQ_TEXT;
      if (mirror_error && pick < 30) begin
        kind = REQ_CLEAR;
      end else if (pick < 40) begin
        b = opener_for(CODE_W'($urandom_range(0, 3)));
      end else if (pick < 65) begin
        if (mirror_depth > 0) b = closer_for(mirror_stack[IDX_W'(mirror_depth - 1)]);
        else b = closer_for(CODE_W'($urandom_range(0, 3)));
      end else if (pick < 70) begin
        b = closer_for(CODE_W'($urandom_range(0, 3)));
      end else if (pick < 82) begin
        kind = REQ_COMPLETE;
      end else if (pick < 85) begin
        kind = REQ_CLEAR;
      end else if (pick < 87) begin
        kind = REQ_UNUSED;
      end
      counted++;
      send_item(kind, b);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req_item = '0;
    mirror_depth = 0;
    mirror_error = 1'b0;
    mirror_overflow = 1'b0;
    steady_flow = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_full_stack();
    test_result_stall();
    test_random();
    req_valid <= 1'b0;

    // Drain owed closers, then give the walk time to settle
    while (owed_closers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (mismatches == 0 && owed_closers.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
